[rtl/core/flywheel_mode_toggle_pid_core_assert.svh]
// ----------------------------------------------------------------------------
// Flywheel mode toggle PID core: assertion macros
// Concurrent checks used inside the core; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef FLYWHEEL_MODE_TOGGLE_PID_CORE_ASSERT_SVH
`define FLYWHEEL_MODE_TOGGLE_PID_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is high.
`define FMTPID_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds while reset is high.
`define FMTPID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FMTPID_ASSERT(lbl, clk, rst, prop, msg)
`define FMTPID_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/core/fmtpid_pkg.sv]
// ----------------------------------------------------------------------------
// Flywheel mode toggle PID package
// Widths, mode codes, register indexes and reset values of the core.
// ----------------------------------------------------------------------------
package fmtpid_pkg;

  localparam int SpeedW  = 10;  // full, base and target speed registers
  localparam int GainW   = 18;  // unsigned Q2.16 gains
  localparam int MeasW   = 11;  // measured speed and command
  localparam int ErrW    = 12;  // target minus measured
  localparam int DerivW  = 13;  // difference of two errors
  localparam int SumW    = 24;  // saturated integral
  localparam int CfgIdxW = 3;
  localparam int FracW   = 16;  // fraction bits of the gains

  localparam int PProdW = ErrW + GainW + 1;
  localparam int IProdW = SumW + GainW + 1;
  localparam int DProdW = DerivW + GainW + 1;
  localparam int PTermW = PProdW - FracW;
  localparam int ITermW = IProdW - FracW;
  localparam int DTermW = DProdW - FracW;
  localparam int CmdSumW = ITermW + 2;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FULL = 2'd1,
    MODE_REG  = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_SPEED   = 3'd0,
    CFG_BASE_SPEED   = 3'd1,
    CFG_TARGET_SPEED = 3'd2,
    CFG_GAIN_P       = 3'd3,
    CFG_GAIN_I       = 3'd4,
    CFG_GAIN_D       = 3'd5
  } cfg_idx_t;

  localparam logic [SpeedW-1:0] FullSpeedRst   = 10'd600;
  localparam logic [SpeedW-1:0] BaseSpeedRst   = 10'd400;
  localparam logic [SpeedW-1:0] TargetSpeedRst = 10'd350;
  localparam logic [GainW-1:0]  GainPRst       = 18'd1966;
  localparam logic [GainW-1:0]  GainIRst       = 18'd0;
  localparam logic [GainW-1:0]  GainDRst       = 18'd6554;

endpackage

[rtl/core/flywheel_mode_toggle_pid_core.sv]
// ----------------------------------------------------------------------------
// Flywheel mode toggle PID core
// Button driven off/full/regulated mode with a PID speed regulator.
// ----------------------------------------------------------------------------
// Usage:
// One input transaction (in_valid/in_ready) is one control tick: two button
// levels and a measured speed. Each tick yields exactly one output transaction
// (out_valid/out_ready) carrying the velocity command and the mode after the
// tick. Registers are written through cfg_we/cfg_index/cfg_data while the
// core is idle; the user must keep to this, as the core does not enforce it;
// indexes above five are ignored. An accepted tick passes through the s1, s2
// and output registers before it is presented on out_valid. Throughput is one
// tick per cycle while out_ready stays high. Mode and integrator state are
// updated in the accept cycle, so ticks may follow back to back; the products
// and the final sum sit in the two following register stages.
// Reset clears the mode to off, the integral and last error to zero, marks
// both buttons released, loads the register defaults and empties the pipe.
// When the receiver stalls, results queue in the three stages; in_ready drops
// only once every stage holds a result.
// ----------------------------------------------------------------------------
`include "flywheel_mode_toggle_pid_core_assert.svh"

module flywheel_mode_toggle_pid_core
  import fmtpid_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [GainW-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      button_full,
  input  logic                      button_regulated,
  input  logic signed [MeasW-1:0]   measured_speed,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [MeasW-1:0]   velocity_command,
  output logic [1:0]                mode
);

  // Configuration registers
  logic [SpeedW-1:0] full_speed, base_speed, target_speed;
  logic [GainW-1:0]  gain_p, gain_i, gain_d;

  // Control state
  logic                     full_released, regulated_released;
  mode_t                    run_mode;
  logic signed [SumW-1:0]   error_sum;
  logic signed [ErrW-1:0]   last_error;

  // Pipeline
  logic                       s1_valid, s2_valid;
  mode_t                      s1_mode, s2_mode, out_mode;
  logic signed [ErrW-1:0]     s1_error;
  logic signed [SumW-1:0]     s1_sum;
  logic signed [DerivW-1:0]   s1_deriv;
  logic signed [PTermW-1:0]   s2_p;
  logic signed [ITermW-1:0]   s2_i;
  logic signed [DTermW-1:0]   s2_d;
  logic signed [MeasW-1:0]    out_cmd;

  logic s1_ready, s2_ready, s3_ready;
  logic in_fire;

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign in_fire  = in_valid && in_ready;

  // ---------------- Accept stage: mode and integrator update ----------------
  logic                     full_edge, reg_edge;
  mode_t                    mode_after_full, run_mode_next;
  logic signed [ErrW-1:0]   error;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   sum_sat;
  logic signed [DerivW-1:0] deriv;

  always_comb begin
    full_edge = button_full && full_released;
    reg_edge  = button_regulated && regulated_released;
    mode_after_full = run_mode;
    if (full_edge) begin
      mode_after_full = (run_mode == MODE_FULL) ? MODE_OFF : MODE_FULL;
    end
    run_mode_next = mode_after_full;
    if (reg_edge) begin
      run_mode_next = (mode_after_full == MODE_REG) ? MODE_OFF : MODE_REG;
    end

    error = signed'({2'b00, target_speed}) - signed'({measured_speed[MeasW-1], measured_speed});
    sum_wide = signed'({error_sum[SumW-1], error_sum})
             + signed'({{(SumW+1-ErrW){error[ErrW-1]}}, error});
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      // Overflow: clamp toward the sign of the true sum.
      sum_sat = sum_wide[SumW] ? signed'({1'b1, {(SumW-1){1'b0}}})
                               : signed'({1'b0, {(SumW-1){1'b1}}});
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
    deriv = signed'({error[ErrW-1], error}) - signed'({last_error[ErrW-1], last_error});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_released      <= 1'b1;
      regulated_released <= 1'b1;
      run_mode           <= MODE_OFF;
      error_sum          <= '0;
      last_error         <= '0;
      s1_valid           <= 1'b0;
    end else begin
      if (in_fire) begin
        full_released      <= !button_full;
        regulated_released <= !button_regulated;
        run_mode           <= run_mode_next;
        if (run_mode_next == MODE_REG) begin
          error_sum  <= sum_sat;
          last_error <= error;
        end
      end
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode  <= run_mode_next;
      s1_error <= error;
      s1_sum   <= sum_sat;
      s1_deriv <= deriv;
    end
  end

  // ---------------- Product stage: scale and truncate toward zero -----------
  logic signed [PProdW-1:0] p_prod;
  logic signed [IProdW-1:0] i_prod;
  logic signed [DProdW-1:0] d_prod;
  logic signed [PTermW-1:0] p_term;
  logic signed [ITermW-1:0] i_term;
  logic signed [DTermW-1:0] d_term;

  always_comb begin
    p_prod = s1_error * signed'({1'b0, gain_p});
    i_prod = s1_sum   * signed'({1'b0, gain_i});
    d_prod = s1_deriv * signed'({1'b0, gain_d});
    // An arithmetic shift floors; negative values with a remainder step up by one.
    p_term = p_prod[PProdW-1:FracW]
           + PTermW'(p_prod[PProdW-1] && (p_prod[FracW-1:0] != '0));
    i_term = i_prod[IProdW-1:FracW]
           + ITermW'(i_prod[IProdW-1] && (i_prod[FracW-1:0] != '0));
    d_term = d_prod[DProdW-1:FracW]
           + DTermW'(d_prod[DProdW-1] && (d_prod[FracW-1:0] != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_mode <= s1_mode;
      s2_p    <= p_term;
      s2_i    <= i_term;
      s2_d    <= d_term;
    end
  end

  // ---------------- Output stage: feedforward, sum and saturate -------------
  logic signed [CmdSumW-1:0] cmd_sum;
  logic signed [MeasW-1:0]   cmd_sel;

  always_comb begin
    cmd_sum = signed'({{(CmdSumW-SpeedW){1'b0}}, base_speed})
            + signed'({{(CmdSumW-PTermW){s2_p[PTermW-1]}}, s2_p})
            + signed'({{(CmdSumW-ITermW){s2_i[ITermW-1]}}, s2_i})
            + signed'({{(CmdSumW-DTermW){s2_d[DTermW-1]}}, s2_d});
    unique case (s2_mode)
      MODE_FULL: cmd_sel = signed'({1'b0, full_speed});
      MODE_REG: begin
        if (cmd_sum > signed'(CmdSumW'(1023))) begin
          cmd_sel = signed'({1'b0, {(MeasW-1){1'b1}}});
        end else if (cmd_sum < -signed'(CmdSumW'(1024))) begin
          cmd_sel = signed'({1'b1, {(MeasW-1){1'b0}}});
        end else begin
          cmd_sel = cmd_sum[MeasW-1:0];
        end
      end
      default: cmd_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      out_mode <= s2_mode;
      out_cmd  <= cmd_sel;
    end
  end

  assign velocity_command = out_cmd;
  assign mode             = out_mode;

  // ---------------- Configuration registers ---------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      full_speed   <= FullSpeedRst;
      base_speed   <= BaseSpeedRst;
      target_speed <= TargetSpeedRst;
      gain_p       <= GainPRst;
      gain_i       <= GainIRst;
      gain_d       <= GainDRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_SPEED:   full_speed   <= cfg_data[SpeedW-1:0];
        CFG_BASE_SPEED:   base_speed   <= cfg_data[SpeedW-1:0];
        CFG_TARGET_SPEED: target_speed <= cfg_data[SpeedW-1:0];
        CFG_GAIN_P:       gain_p       <= cfg_data;
        CFG_GAIN_I:       gain_i       <= cfg_data;
        CFG_GAIN_D:       gain_d       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- Assertions ----------------------------------------------
  `FMTPID_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !out_valid, "output valid after reset")
  `FMTPID_ASSERT(a_off_cmd_zero, clk, rst, (out_valid && out_mode == MODE_OFF) |-> (out_cmd == '0), "nonzero command in off mode")
  `FMTPID_ASSERT(a_full_cmd, clk, rst, (out_valid && out_mode == MODE_FULL) |-> (out_cmd == signed'({1'b0, full_speed})), "full mode command mismatch")
  `FMTPID_ASSERT(a_integral_hold, clk, rst, !(in_fire && run_mode_next == MODE_REG) |=> $stable(error_sum), "integral moved outside a regulated tick")
  `FMTPID_ASSERT(a_stall_only_when_full, clk, rst, !in_ready |-> (s1_valid && s2_valid && out_valid), "input stalled with a free stage")

endmodule

[sim/flywheel_command_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flywheel command checker
// Watches both channels and the register port of the flywheel core. It keeps
// its own copy of the mode, button and regulator state, and it computes the
// command and mode of every tick. Each result that leaves the core is matched
// against the oldest prediction.
// ----------------------------------------------------------------------------
module flywheel_command_checker
  import fmtpid_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [GainW-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    button_full,
  input  logic                    button_regulated,
  input  logic signed [MeasW-1:0] measured_speed,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [MeasW-1:0] velocity_command,
  input  logic [1:0]              mode,
  input  logic                    run_done,
  output int                      pending,
  output int                      results_checked,
  output int                      fail_count
);

  localparam longint GainOne = 64'sd1 << FracW;
  localparam longint SumMax  = (64'sd1 <<< (SumW - 1)) - 1;
  localparam longint SumMin  = -(64'sd1 <<< (SumW - 1));
  localparam longint CmdMax  = (64'sd1 <<< (MeasW - 1)) - 1;
  localparam longint CmdMin  = -(64'sd1 <<< (MeasW - 1));
  localparam int     MaxPrinted = 40;

  typedef struct {
    logic signed [MeasW-1:0] command;
    mode_t                   mode;
  } flywheel_result_t;

  // Register copies.
  logic [SpeedW-1:0] full_cmd, feedforward, setpoint;
  logic [GainW-1:0]  kp, ki, kd;

  // Control state.
  logic                   full_armed, reg_armed;
  mode_t                  cur_mode;
  logic signed [SumW-1:0] err_total;
  logic signed [ErrW-1:0] prev_err;

  flywheel_result_t expected_q [$];
  logic             leftover_checked;

  task automatic report_mismatch(input string what);
    if (fail_count < MaxPrinted)
      $display("%0t ns  mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic longint scale_by_gain(input longint value, input logic [GainW-1:0] gain);
    // Signed division truncates toward zero, as the core does.
    return (value * longint'(gain)) / GainOne;
  endfunction

  function automatic void write_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [GainW-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_FULL_SPEED:   full_cmd    = data[SpeedW-1:0];
      CFG_BASE_SPEED:   feedforward = data[SpeedW-1:0];
      CFG_TARGET_SPEED: setpoint    = data[SpeedW-1:0];
      CFG_GAIN_P:       kp          = data;
      CFG_GAIN_I:       ki          = data;
      CFG_GAIN_D:       kd          = data;
      default: ;
    endcase
  endfunction

  function automatic flywheel_result_t advance_flywheel(input logic bf, input logic br,
                                                        input logic signed [MeasW-1:0] meas);
    flywheel_result_t r;
    longint err, sum, deriv, cmd;
    if (!bf) full_armed = 1'b1;
    if (bf && full_armed) begin
      full_armed = 1'b0;
      cur_mode = (cur_mode == MODE_FULL) ? MODE_OFF : MODE_FULL;
    end
    if (!br) reg_armed = 1'b1;
    if (br && reg_armed) begin
      reg_armed = 1'b0;
      cur_mode = (cur_mode == MODE_REG) ? MODE_OFF : MODE_REG;
    end
    cmd = 0;
    if (cur_mode == MODE_FULL) begin
      cmd = longint'(full_cmd);
    end else if (cur_mode == MODE_REG) begin
      err = longint'(setpoint) - longint'(meas);
      sum = longint'(err_total) + err;
      if (sum > SumMax) sum = SumMax;
      if (sum < SumMin) sum = SumMin;
      err_total = sum[SumW-1:0];
      deriv = err - longint'(prev_err);
      prev_err = err[ErrW-1:0];
      cmd = longint'(feedforward) + scale_by_gain(err, kp) + scale_by_gain(sum, ki) +
            scale_by_gain(deriv, kd);
      if (cmd > CmdMax) cmd = CmdMax;
      if (cmd < CmdMin) cmd = CmdMin;
    end
    r.command = cmd[MeasW-1:0];
    r.mode = cur_mode;
    return r;
  endfunction

  always @(posedge clk) begin
    flywheel_result_t want;
    if (rst) begin
      full_cmd = FullSpeedRst;
      feedforward = BaseSpeedRst;
      setpoint = TargetSpeedRst;
      kp = GainPRst;
      ki = GainIRst;
      kd = GainDRst;
      full_armed = 1'b1;
      reg_armed = 1'b1;
      cur_mode = MODE_OFF;
      err_total = '0;
      prev_err = '0;
      expected_q.delete();
      leftover_checked = 1'b0;
      results_checked = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready)
        expected_q.push_back(advance_flywheel(button_full, button_regulated, measured_speed));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with command %0d, mode %0d and no tick waiting",
                                    velocity_command, mode));
        end else begin
          want = expected_q.pop_front();
          if (velocity_command !== want.command)
            report_mismatch($sformatf("result %0d: velocity_command %0d, expected %0d",
                                      results_checked, velocity_command, want.command));
          if (mode !== want.mode)
            report_mismatch($sformatf("result %0d: mode %0d, expected %0d",
                                      results_checked, mode, want.mode));
          results_checked++;
        end
      end
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_q.size() != 0)
          report_mismatch($sformatf("%0d results never came out", expected_q.size()));
      end
    end
    pending <= expected_q.size();
  end

endmodule

[sim/flywheel_mode_toggle_pid_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flywheel mode toggle PID core testbench
// Drives control ticks into the core under changing register settings and
// handshake pacing, while a checker beside the core predicts every command
// and mode. A short directed run covers button edges, holds and mode changes;
// random ticks under several register settings and pacing mixes follow.
// ----------------------------------------------------------------------------
module flywheel_mode_toggle_pid_core_tb;
  import fmtpid_pkg::*;

  localparam int StallLimit = 5000;
  localparam int PipeDepth  = 4;

  typedef enum {SET_MODERATE, SET_WIDE, SET_MAX, SET_ZERO} setting_kind_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [GainW-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    button_full = 1'b0;
  logic                    button_regulated = 1'b0;
  logic signed [MeasW-1:0] measured_speed = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [MeasW-1:0] velocity_command;
  logic [1:0]              mode;
  logic                    run_done = 1'b0;

  int    pending, results_checked, fail_count;
  int    tx_idle_pct = 15;
  int    rx_idle_pct = 78;
  int    ticks_sent = 0;
  int    settings_used = 0;
  int    stall_cycles = 0;
  logic  bf_level = 1'b0;
  logic  br_level = 1'b0;
  logic [SpeedW-1:0] cur_target = TargetSpeedRst;

  flywheel_mode_toggle_pid_core uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .button_full      (button_full),
    .button_regulated (button_regulated),
    .measured_speed   (measured_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .velocity_command (velocity_command),
    .mode             (mode)
  );

  flywheel_command_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .button_full      (button_full),
    .button_regulated (button_regulated),
    .measured_speed   (measured_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .velocity_command (velocity_command),
    .mode             (mode),
    .run_done         (run_done),
    .pending          (pending),
    .results_checked  (results_checked),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("no transaction for %0d cycles", StallLimit);
      $display("flywheel_mode_toggle_pid_core_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_tick(input logic bf, input logic br, input logic signed [MeasW-1:0] meas);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    button_full <= bf;
    button_regulated <= br;
    measured_speed <= meas;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Holds the sender off until the checker has seen every result.
  task automatic drain_core();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes all six registers and both spare indexes. Unused upper data bits
  // carry random junk that the core must drop.
  task automatic load_settings(input logic [SpeedW-1:0] full_v, base_v, target_v,
                               input logic [GainW-1:0] p_v, i_v, d_v);
    logic [GainW-1:0] word [1 << CfgIdxW];
    for (int idx = 0; idx < (1 << CfgIdxW); idx++) word[idx] = GainW'($urandom);
    word[CFG_FULL_SPEED][SpeedW-1:0] = full_v;
    word[CFG_BASE_SPEED][SpeedW-1:0] = base_v;
    word[CFG_TARGET_SPEED][SpeedW-1:0] = target_v;
    word[CFG_GAIN_P] = p_v;
    word[CFG_GAIN_I] = i_v;
    word[CFG_GAIN_D] = d_v;
    drain_core();
    repeat (PipeDepth) @(posedge clk);
    for (int idx = 0; idx < (1 << CfgIdxW); idx++) begin
      cfg_we <= 1'b1;
      cfg_index <= CfgIdxW'(idx);
      cfg_data <= word[idx];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_target = target_v;
    settings_used++;
  endtask

  task automatic choose_settings(input setting_kind_t kind);
    case (kind)
      SET_MODERATE: load_settings(SpeedW'($urandom), SpeedW'($urandom), SpeedW'($urandom),
                                  GainW'($urandom_range(16383)), GainW'($urandom_range(255)),
                                  GainW'($urandom_range(32767)));
      SET_WIDE:     load_settings(SpeedW'($urandom), SpeedW'($urandom), SpeedW'($urandom),
                                  GainW'($urandom), GainW'($urandom), GainW'($urandom));
      SET_MAX:      load_settings('1, '1, '1, '1, '1, '1);
      default:      load_settings('0, '0, '0, '0, '0, '0);
    endcase
  endtask

  // Button levels toggle now and then so that presses are held for a while;
  // a few ticks carry random levels. Speeds mostly hover near the setpoint.
  task automatic run_random_ticks(input int count);
    int m;
    int pick;
    logic signed [MeasW-1:0] meas;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 10) bf_level = ~bf_level;
      if ($urandom_range(99) < 10) br_level = ~br_level;
      if ($urandom_range(99) < 5) begin
        bf_level = 1'($urandom_range(1));
        br_level = 1'($urandom_range(1));
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        m = int'(cur_target) + int'($urandom_range(64)) - 32;
        meas = m[MeasW-1:0];
      end else if (pick < 85) begin
        meas = MeasW'($urandom);
      end else begin
        meas = $urandom_range(1) ? {1'b0, {(MeasW-1){1'b1}}} : {1'b1, {(MeasW-1){1'b0}}};
      end
      send_tick(bf_level, br_level, meas);
      if ($urandom_range(199) == 0) drain_core();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks under the reset settings.
    send_tick(1'b0, 1'b0, MeasW'(0));
    send_tick(1'b1, 1'b0, MeasW'(100));
    send_tick(1'b1, 1'b0, MeasW'(-1024));   // held full button
    send_tick(1'b0, 1'b0, MeasW'(1023));
    send_tick(1'b1, 1'b0, MeasW'(0));       // full toggles back to off
    send_tick(1'b0, 1'b1, MeasW'(-1024));   // regulated with the largest error
    send_tick(1'b0, 1'b1, MeasW'(1023));    // held, most negative error
    send_tick(1'b0, 1'b0, MeasW'(350));
    send_tick(1'b1, 1'b0, MeasW'(-5));      // full button leaves regulated mode
    send_tick(1'b0, 1'b1, MeasW'(7));       // regulated button leaves full mode
    send_tick(1'b0, 1'b0, MeasW'(-300));
    send_tick(1'b1, 1'b1, MeasW'(400));     // both edges at once
    send_tick(1'b0, 1'b0, MeasW'(0));
    send_tick(1'b0, 1'b1, MeasW'(12));
    send_tick(1'b0, 1'b0, MeasW'(0));
    send_tick(1'b1, 1'b1, MeasW'(-700));

    // Largest settings: the regulated command saturates at the top.
    choose_settings(SET_MAX);
    send_tick(1'b0, 1'b0, MeasW'(-1024));
    send_tick(1'b0, 1'b0, MeasW'(1023));
    send_tick(1'b1, 1'b0, MeasW'(0));

    // All zero settings.
    choose_settings(SET_ZERO);
    send_tick(1'b0, 1'b0, MeasW'(0));
    send_tick(1'b0, 1'b1, MeasW'(-1024));
    send_tick(1'b0, 1'b0, MeasW'(1023));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 15; rx_idle_pct = 78; end
        1: begin tx_idle_pct = 78; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < 4; chunk++) begin
        choose_settings(setting_kind_t'((phase + chunk) % 4));
        run_random_ticks(160);
      end
    end

    drain_core();
    repeat (2 * PipeDepth) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    $display("Ran %0d ticks under %0d register settings; %0d results compared.",
             ticks_sent, settings_used, results_checked);
    $display("Covered button edges and holds, all modes, register extremes and "
             , "three pacing mixes.");
    if (fail_count == 0) begin
      $display("flywheel_mode_toggle_pid_core_tb OK");
    end else begin
      $display("flywheel_mode_toggle_pid_core_tb NOT OK");
    end
    $finish;
  end

endmodule
